@@ rtl/ott_pkg.sv @@
// ----------------------------------------------------------------------------
// ott_pkg
// Types and constants shared by the ordered task table.
// ----------------------------------------------------------------------------
package ott_pkg;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned RANK_W = 8;
    localparam int unsigned HDL_W  = 32;
    localparam int unsigned ENT_W  = KEY_W + RANK_W + HDL_W;
    localparam int unsigned CNT_W  = 7;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_SORT   = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_COUNT  = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic [HDL_W-1:0]  handle;
    } t_entry;

    // signed id compare: a < b
    function automatic logic id_less(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // sort key compare: entry a ranks before entry b
    function automatic logic ent_less(input t_entry a, input t_entry b);
        return (a.rank < b.rank) || ((a.rank == b.rank) && id_less(a.key, b.key));
    endfunction

endpackage

@@ rtl/ott_ram.sv @@
// ----------------------------------------------------------------------------
// ott_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ott_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ordered_task_table.sv @@
// ----------------------------------------------------------------------------
// ordered_task_table
// Bounded task table kept in list order, one command per transfer.
// ----------------------------------------------------------------------------
// Usage: a command transfer on the s_axis side (command, id, priority,
// payload) yields exactly one result transfer on m_axis (status, found,
// match_count, entries). The block takes one command at a time: s_axis_tready
// is low from acceptance until the result has been taken.
// All entries live in one RAM with a registered read port; a single
// sequencer walks it one access per cycle, so the table walk sets the time:
//   find / count        : one scan of the held entries
//   append              : write at the end; full table: refused (ST_FULL)
//   ordered insert      : scan, then shift up; full table: refused (ST_FULL)
//   remove              : scan, then shift down
//   sort                : exchange sort, one compare of the
//                         entry held for i against entry j per pair
// A stalled m_axis_tready simply holds the result register; nothing is lost.
// Reset clears the entry count; no RAM clearing pass is needed since only
// data from positions below the count is used.
// ----------------------------------------------------------------------------
module ordered_task_table
    import ott_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] command, [34:3] task_id, [42:35] priority_req, [74:43] payload
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] found, [9:3] match_count, [16:10] entries
    output logic [23:0] m_axis_tdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned TW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHUP_RD, S_SHUP_WR, S_PUT,
        S_SHDN_RD, S_SHDN_WR, S_SORT_RDI, S_SORT_RDJ, S_SORT_CMP,
        S_SORT_WRI, S_OUT
    } t_state;

    t_state            r_state;
    logic [2:0]        r_cmd;
    logic [KEY_W-1:0]  r_id;
    logic [RANK_W-1:0] r_prio;
    logic [HDL_W-1:0]  r_hdl;
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     r_i, r_j;
    logic [TW-1:0]     r_cnt;
    t_entry            r_ei;
    logic [1:0]        r_status;
    logic              r_found;
    logic [CNT_W-1:0]  r_mcount;
    logic [CNT_W-1:0]  r_entries;
    logic              r_ovalid;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    t_entry            wdata, rdata;
    logic [ENT_W-1:0]  rdata_raw;

    ott_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    function automatic logic [CNT_W-1:0] sat7(input logic [TW-1:0] v);
        if (v > TW'(127)) return CNT_W'(127);
        return CNT_W'(v);
    endfunction

    t_entry new_ent;
    assign new_ent = '{key: r_id, rank: r_prio, handle: r_hdl};

    always_comb begin
        we    = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = new_ent;
        raddr = r_i[AW-1:0];
        unique case (r_state)
            S_SHUP_RD: raddr = AW'(r_j - TW'(1));
            S_SHUP_WR: begin
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = rdata;
            end
            S_PUT:     we = 1'b1;
            S_SHDN_RD: raddr = AW'(r_i + TW'(1));
            S_SHDN_WR: begin
                we    = 1'b1;
                wdata = rdata;
            end
            S_SORT_RDJ: raddr = r_j[AW-1:0];
            S_SORT_CMP: begin
                // swap: j gets the entry held for position i in r_ei
                we    = ent_less(rdata, r_ei);
                waddr = r_j[AW-1:0];
                wdata = r_ei;
            end
            S_SORT_WRI: begin
                we    = 1'b1;
                wdata = r_ei;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_entries, r_mcount, r_found, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cmd    <= s_axis_tdata[2:0];
                    r_id     <= s_axis_tdata[34:3];
                    r_prio   <= s_axis_tdata[42:35];
                    r_hdl    <= s_axis_tdata[74:43];
                    r_status <= ST_DONE;
                    r_found  <= 1'b0;
                    r_mcount <= '0;
                    r_cnt    <= '0;
                    r_i      <= '0;
                    case (s_axis_tdata[2:0]) inside
                        CMD_APPEND, CMD_INSERT: begin
                            if (r_total == TW'(DEPTH)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else if (s_axis_tdata[2:0] == CMD_APPEND) begin
                                r_i     <= r_total;
                                r_state <= S_PUT;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                        CMD_SORT, CMD_REMOVE, CMD_FIND, CMD_COUNT: begin
                            if (s_axis_tdata[2:0] == CMD_SORT) r_state <= S_SORT_RDI;
                            else r_state <= S_SCAN_RD;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SCAN_RD: begin
                    if (r_i >= r_total) begin
                        // ran off the end
                        if (r_cmd == CMD_INSERT) begin
                            r_j     <= r_total;
                            r_state <= S_SHUP_RD;
                        end else begin
                            if (r_cmd != CMD_COUNT) r_status <= ST_NOTFOUND;
                            if (r_cmd == CMD_COUNT) r_mcount <= sat7(r_cnt);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    r_state <= S_SCAN_RD;
                    r_i     <= r_i + TW'(1);
                    case (r_cmd)
                        CMD_COUNT:
                            if (rdata.rank == r_prio) r_cnt <= r_cnt + TW'(1);
                        CMD_FIND:
                            if (rdata.key == r_id) begin
                                r_found <= 1'b1;
                                r_state <= S_OUT;
                            end
                        CMD_REMOVE:
                            if (rdata.key == r_id) begin
                                r_found <= 1'b1;
                                r_i     <= r_i;
                                r_state <= S_SHDN_RD;
                            end
                        default: begin
                            // insert: stop at 0 if id < key there, else at the
                            // first later position whose key is not below id
                            if ((r_i == '0) ? id_less(r_id, rdata.key)
                                            : !id_less(rdata.key, r_id)) begin
                                r_i     <= r_i;
                                r_j     <= r_total;
                                r_state <= S_SHUP_RD;
                            end else if (r_i == '0 && r_total == TW'(1)) begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                    endcase
                end
                S_SHUP_RD: begin
                    if (r_j == r_i) r_state <= S_PUT;
                    else r_state <= S_SHUP_WR;
                end
                S_SHUP_WR: begin
                    r_j     <= r_j - TW'(1);
                    r_state <= S_SHUP_RD;
                end
                S_PUT: begin
                    r_total <= r_total + TW'(1);
                    r_state <= S_OUT;
                end
                S_SHDN_RD: begin
                    if (r_i + TW'(1) >= r_total) begin
                        r_total <= r_total - TW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SHDN_WR;
                    end
                end
                S_SHDN_WR: begin
                    r_i     <= r_i + TW'(1);
                    r_state <= S_SHDN_RD;
                end
                S_SORT_RDI: begin
                    if (r_i + TW'(1) >= r_total) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_i + TW'(1);
                        r_state <= S_SORT_RDJ;
                    end
                end
                S_SORT_RDJ: begin
                    // first pass after RDI: latch entry i
                    if (r_j == r_i + TW'(1)) r_ei <= rdata;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_CMP: begin
                    if (ent_less(rdata, r_ei)) r_ei <= rdata;
                    if (r_j + TW'(1) >= r_total) begin
                        r_state <= S_SORT_WRI;
                    end else begin
                        r_j     <= r_j + TW'(1);
                        r_state <= S_SORT_RDJ;
                    end
                end
                S_SORT_WRI: begin
                    r_i     <= r_i + TW'(1);
                    r_state <= S_SORT_RDI;
                end
                S_OUT: if (!r_ovalid) begin
                    r_entries <= sat7(r_total);
                    r_ovalid  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // r_ei latch in SORT_RDJ needs rdata of entry i: RDI reads i, RDJ sees it.
    // Later RDJ visits keep r_ei since j > i+1.

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready after accept");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(m_axis_tdata))
        else $error("result lost under stall");

endmodule
